// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ipfhg_pkg.sv =====
package ipfhg_pkg;

  localparam int unsigned HEADER_BYTES  = 60;
  localparam int unsigned MAX_FRAGMENTS = 64;

  localparam logic [7:0]  UNITS_MIN     = 8'd128;
  localparam logic [7:0]  UNITS_MAX     = 8'd180;
  localparam logic [7:0]  VER_IHL       = 8'h4f;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_MAX_UNITS = 3'd0;
  localparam logic [2:0] REG_SRC_ADDR  = 3'd1;
  localparam logic [2:0] REG_DST_ADDR  = 3'd2;
  localparam logic [2:0] REG_TTL       = 3'd3;
  localparam logic [2:0] REG_TOS       = 3'd4;
  localparam logic [2:0] REG_PROTO     = 3'd5;

  // Operations of the checksum accumulator.
  localparam logic [2:0] CS_NOP     = 3'd0;
  localparam logic [2:0] CS_CLEAR   = 3'd1;
  localparam logic [2:0] CS_ADD     = 3'd2;
  localparam logic [2:0] CS_SAVE    = 3'd3;
  localparam logic [2:0] CS_RESTORE = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] word;
  } cs_ctl_t;

  typedef struct packed {
    logic        carry;
    logic [15:0] checksum;
  } cs_stat_t;

endpackage

// ===== rtl/ipfhg_csum_unit.sv =====
// One's-complement accumulator with a deferred end-around carry. The single
// 17-bit adder is shared by every word of every header; the carry out of one
// addition is fed back as the carry in of the next.
module ipfhg_csum_unit
  import ipfhg_pkg::*;
(
  input  logic     clk,
  input  cs_ctl_t  ctl,
  output cs_stat_t stat
);

  logic [15:0] acc_r, acc_nxt;
  logic        c_r, c_nxt;
  logic [15:0] base_acc_r, base_acc_nxt;
  logic        base_c_r, base_c_nxt;
  logic [16:0] sum;

  assign sum = {1'b0, acc_r} + {1'b0, ctl.word} + {16'd0, c_r};

  always_comb begin
    acc_nxt      = acc_r;
    c_nxt        = c_r;
    base_acc_nxt = base_acc_r;
    base_c_nxt   = base_c_r;
    unique case (ctl.op)
      CS_NOP: begin
      end
      CS_CLEAR: begin
        acc_nxt = '0;
        c_nxt   = 1'b0;
      end
      CS_ADD: begin
        acc_nxt = sum[15:0];
        c_nxt   = sum[16];
      end
      CS_SAVE: begin
        base_acc_nxt = acc_r;
        base_c_nxt   = c_r;
      end
      CS_RESTORE: begin
        acc_nxt = base_acc_r;
        c_nxt   = base_c_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    c_r        <= c_nxt;
    base_acc_r <= base_acc_nxt;
    base_c_r   <= base_c_nxt;
  end

  assign stat.carry    = c_r;
  assign stat.checksum = ~acc_r;

endmodule

// ===== rtl/ipv4_fragment_header_gen.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_payload_length
// out_      output     out_valid/out_stall identification .. last_fragment
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A datagram of nonzero length is split into at most 64 fragments; the single
// shared checksum adder, which adds one header word per cycle, paces its work,
// and a stalled output holds it up.
// A zero length item only advances the identifier.
// Reset (rst_n low, synchronous) restores the register defaults and clears the
// identifier. in_stall is high while a datagram is being worked on.
// A stalled result holds its fields until it is taken.
module ipv4_fragment_header_gen
  import ipfhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_payload_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_identification,
  output logic [15:0] out_flags_offset_word,
  output logic [10:0] out_ip_length,
  output logic [15:0] out_header_checksum,
  output logic [10:0] out_fragment_bytes,
  output logic [15:0] out_byte_offset,
  output logic        out_last_fragment,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BASE  = 3'd1;
  localparam logic [2:0] ST_SAVE  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_SUM0  = 3'd4;
  localparam logic [2:0] ST_SUM1  = 3'd5;
  localparam logic [2:0] ST_FOLD  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [2:0]  BASE_LAST = 3'd6;
  localparam logic [5:0]  FRAG_LAST = 6'(MAX_FRAGMENTS - 1);
  localparam logic [10:0] HDR_LEN   = 11'(HEADER_BYTES);

  // Configuration registers.
  logic [7:0]  units_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [7:0]  ttl_r;
  logic [7:0]  tos_r;
  logic [7:0]  proto_r;

  // Datagram and fragment state.
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] pid_r, pid_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] off_r, off_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [10:0] frag_r, frag_nxt;

  // Result registers.
  logic [15:0] fo_r, fo_nxt;
  logic [10:0] tl_r, tl_nxt;
  logic [10:0] bytes_r, bytes_nxt;
  logic        last_r, last_nxt;
  logic [15:0] csum_r, csum_nxt;

  logic [7:0]  units_clamped;
  logic [15:0] rest;
  logic        rest_fits;
  logic [15:0] base_word;
  logic        in_acc;
  logic        out_acc;

  cs_ctl_t  cs_ctl;
  cs_stat_t cs_stat;

  ipfhg_csum_unit u_csum (
    .clk  (clk),
    .ctl  (cs_ctl),
    .stat (cs_stat)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r <= 8'd180;
      src_r   <= 32'h0A14_024B;
      dst_r   <= 32'hFFFF_FFFF;
      ttl_r   <= 8'd64;
      tos_r   <= 8'hFE;
      proto_r <= 8'd6;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_UNITS: units_r <= cfg_data[7:0];
        REG_SRC_ADDR:  src_r   <= cfg_data;
        REG_DST_ADDR:  dst_r   <= cfg_data;
        REG_TTL:       ttl_r   <= cfg_data[7:0];
        REG_TOS:       tos_r   <= cfg_data[7:0];
        REG_PROTO:     proto_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Fragment size, limited to the supported range of units.
  always_comb begin
    if (units_r < UNITS_MIN) begin
      units_clamped = UNITS_MIN;
    end else if (units_r > UNITS_MAX) begin
      units_clamped = UNITS_MAX;
    end else begin
      units_clamped = units_r;
    end
  end

  // Remaining payload decides whether this is the final fragment.
  assign rest      = len_r - off_r;
  assign rest_fits = (rest <= {5'd0, frag_r});

  // Header words that stay the same for every fragment of a datagram.
  always_comb begin
    case (step_r)
      3'd0:    base_word = {VER_IHL, tos_r};
      3'd1:    base_word = pid_r;
      3'd2:    base_word = {ttl_r, proto_r};
      3'd3:    base_word = src_r[31:16];
      3'd4:    base_word = src_r[15:0];
      3'd5:    base_word = dst_r[31:16];
      3'd6:    base_word = dst_r[15:0];
      default: base_word = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    pid_nxt     = pid_r;
    len_nxt     = len_r;
    off_nxt     = off_r;
    cnt_nxt     = cnt_r;
    frag_nxt    = frag_r;
    fo_nxt      = fo_r;
    tl_nxt      = tl_r;
    bytes_nxt   = bytes_r;
    last_nxt    = last_r;
    csum_nxt    = csum_r;
    cs_ctl.op   = CS_NOP;
    cs_ctl.word = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_payload_length == 16'd0) begin
            pid_nxt = pid_r + 16'd1;
          end else begin
            len_nxt   = in_payload_length;
            off_nxt   = '0;
            cnt_nxt   = '0;
            step_nxt  = '0;
            frag_nxt  = {units_clamped, 3'b000};
            cs_ctl.op = CS_CLEAR;
            state_nxt = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        cs_ctl.op   = CS_ADD;
        cs_ctl.word = base_word;
        step_nxt    = step_r + 3'd1;
        if (step_r == BASE_LAST) begin
          state_nxt = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cs_ctl.op = CS_SAVE;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        last_nxt  = rest_fits;
        bytes_nxt = rest_fits ? rest[10:0] : frag_r;
        fo_nxt    = {2'b00, !rest_fits, off_r[15:3]};
        tl_nxt    = (rest_fits ? rest[10:0] : frag_r) + HDR_LEN;
        cs_ctl.op = CS_RESTORE;
        state_nxt = ST_SUM0;
      end
      ST_SUM0: begin
        cs_ctl.op   = CS_ADD;
        cs_ctl.word = {5'd0, tl_r};
        state_nxt   = ST_SUM1;
      end
      ST_SUM1: begin
        cs_ctl.op   = CS_ADD;
        cs_ctl.word = fo_r;
        state_nxt   = ST_FOLD;
      end
      ST_FOLD: begin
        // Wrap the pending carry back in until none is left.
        if (cs_stat.carry) begin
          cs_ctl.op = CS_ADD;
        end else begin
          csum_nxt  = cs_stat.checksum;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          off_nxt = off_r + {5'd0, bytes_r};
          cnt_nxt = cnt_r + 6'd1;
          if (!last_r && cnt_r != FRAG_LAST) begin
            state_nxt = ST_SETUP;
          end else begin
            pid_nxt   = pid_r + 16'd1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pid_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pid_r   <= pid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    len_r   <= len_nxt;
    off_r   <= off_nxt;
    cnt_r   <= cnt_nxt;
    frag_r  <= frag_nxt;
    fo_r    <= fo_nxt;
    tl_r    <= tl_nxt;
    bytes_r <= bytes_nxt;
    last_r  <= last_nxt;
    csum_r  <= csum_nxt;
  end

  assign out_identification    = pid_r;
  assign out_flags_offset_word = fo_r;
  assign out_ip_length         = tl_r;
  assign out_header_checksum   = csum_r;
  assign out_fragment_bytes    = bytes_r;
  assign out_byte_offset       = off_r;
  assign out_last_fragment     = last_r;

  // The input side is never open while a result is pending.
  `ASSERT_NOW(a_no_accept_with_result, !in_stall, !out_valid)
  // Only the final fragment clears the more-fragments flag.
  `ASSERT_NOW(a_mf_flag, out_valid, out_flags_offset_word[13] == !out_last_fragment)
  // Total length is always the fragment size plus the fixed header.
  `ASSERT_NOW(a_ip_length, out_valid, out_ip_length == out_fragment_bytes + HDR_LEN)
  // Delivering a final fragment ends the datagram and frees the input.
  `ASSERT_NEXT(a_last_frees_input, out_valid && !out_stall && out_last_fragment, !in_stall)

endmodule

// ===== dv/ipv4_fragment_header_gen_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the fragment header generator, keeps its own
// copy of the registers and the identifier, and checks every result item in
// order against the fragments that each accepted datagram should produce.
module ipv4_fragment_header_gen_checker
  import ipfhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_payload_length,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_identification,
  input  logic [15:0] out_flags_offset_word,
  input  logic [10:0] out_ip_length,
  input  logic [15:0] out_header_checksum,
  input  logic [10:0] out_fragment_bytes,
  input  logic [15:0] out_byte_offset,
  input  logic        out_last_fragment,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,

  output int          error_count,
  output int          pending_count,
  output int          datagram_count,
  output int          fragment_count
);

  typedef struct packed {
    logic [15:0] identification;
    logic [15:0] flags_offset_word;
    logic [10:0] ip_length;
    logic [15:0] header_checksum;
    logic [10:0] fragment_bytes;
    logic [15:0] byte_offset;
    logic        last_fragment;
  } fragment_t;

  fragment_t   fragment_q[$];
  fragment_t   want;
  int          errors;
  int          datagrams;
  int          fragments;

  logic [7:0]  units_reg;
  logic [31:0] src_reg;
  logic [31:0] dst_reg;
  logic [7:0]  ttl_reg;
  logic [7:0]  tos_reg;
  logic [7:0]  proto_reg;
  logic [15:0] next_id;

  // Internet checksum over the nine nonzero header words; the option words
  // and the checksum field itself contribute nothing.
  function automatic logic [15:0] header_checksum(input logic [10:0] tot_len,
                                                   input logic [15:0] ident,
                                                   input logic [15:0] fo);
    logic [19:0] acc;
    acc = {4'h0, VER_IHL, tos_reg} + {9'h0, tot_len} + {4'h0, ident}
        + {4'h0, fo} + {4'h0, ttl_reg, proto_reg}
        + {4'h0, src_reg[31:16]} + {4'h0, src_reg[15:0]}
        + {4'h0, dst_reg[31:16]} + {4'h0, dst_reg[15:0]};
    while (acc[19:16] != 4'h0)
      acc = {4'h0, acc[15:0]} + {16'h0, acc[19:16]};
    return ~acc[15:0];
  endfunction

  task automatic split_datagram(input logic [15:0] len);
    logic [7:0]  units;
    logic [10:0] piece;
    int unsigned off;
    int unsigned rest;
    int          n;
    fragment_t   f;
    units = units_reg;
    if (units < UNITS_MIN) units = UNITS_MIN;
    if (units > UNITS_MAX) units = UNITS_MAX;
    piece = {units, 3'b000};
    off = 0;
    n = 0;
    while (off < len && n < MAX_FRAGMENTS) begin
      rest = len - off;
      f.last_fragment = (rest <= piece);
      f.fragment_bytes = f.last_fragment ? 11'(rest) : piece;
      f.flags_offset_word = {2'b00, !f.last_fragment, off[15:3]};
      f.ip_length = f.fragment_bytes + 11'(HEADER_BYTES);
      f.identification = next_id;
      f.header_checksum = header_checksum(f.ip_length, next_id, f.flags_offset_word);
      f.byte_offset = off[15:0];
      fragment_q.push_back(f);
      off += f.fragment_bytes;
      n++;
    end
    next_id = next_id + 16'd1;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      units_reg = UNITS_MAX;
      src_reg   = 32'h0A14_024B;
      dst_reg   = 32'hFFFF_FFFF;
      ttl_reg   = 8'd64;
      tos_reg   = 8'hFE;
      proto_reg = 8'd6;
      next_id   = '0;
      fragment_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_UNITS: units_reg = cfg_data[7:0];
          REG_SRC_ADDR:  src_reg   = cfg_data;
          REG_DST_ADDR:  dst_reg   = cfg_data;
          REG_TTL:       ttl_reg   = cfg_data[7:0];
          REG_TOS:       tos_reg   = cfg_data[7:0];
          REG_PROTO:     proto_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        split_datagram(in_payload_length);
        datagrams++;
      end
      if (out_valid && !out_stall) begin
        fragments++;
        if (fragment_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual id %0h offset %0h",
                   $time, out_identification, out_byte_offset);
        end else begin
          want = fragment_q.pop_front();
          check_field("identification", want.identification, out_identification);
          check_field("flags_offset_word", want.flags_offset_word, out_flags_offset_word);
          check_field("ip_length", 16'(want.ip_length), 16'(out_ip_length));
          check_field("header_checksum", want.header_checksum, out_header_checksum);
          check_field("fragment_bytes", 16'(want.fragment_bytes), 16'(out_fragment_bytes));
          check_field("byte_offset", want.byte_offset, out_byte_offset);
          check_field("last_fragment", 16'(want.last_fragment), 16'(out_last_fragment));
        end
      end
    end
    error_count    <= errors;
    pending_count  <= fragment_q.size();
    datagram_count <= datagrams;
    fragment_count <= fragments;
  end

endmodule

// ===== dv/ipv4_fragment_header_gen_test.sv =====
`timescale 1ns / 1ps

// Top of the fragment header generator testbench. This module only makes
// stimulus: datagram lengths on the input channel, register writes between
// phases, and stalls on the result channel. The checker beside the block does
// all prediction and comparison and hands back its failure count.
module ipv4_fragment_header_gen_test;
  import ipfhg_pkg::*;

  localparam int unsigned     RESET_CYCLES  = 7;
  // Cycles allowed after the last result before a register write or the end,
  // covering a zero length item still in flight and the return to idle.
  localparam int unsigned     SETTLE_CYCLES = 32;
  // Length of the long receiver hold-off that backs the block up.
  localparam int unsigned     HOLD_CYCLES   = 400;
  // Roughly 100 datagrams of at most 64 fragments each, stalls included, fit
  // well inside this limit.
  localparam longint unsigned RUN_LIMIT_NS  = 20_000_000;

  // Register indexes that select no register; writes to them must be ignored.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_payload_length;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_identification;
  logic [15:0] out_flags_offset_word;
  logic [10:0] out_ip_length;
  logic [15:0] out_header_checksum;
  logic [10:0] out_fragment_bytes;
  logic [15:0] out_byte_offset;
  logic        out_last_fragment;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int error_count;
  int pending_count;
  int datagram_count;
  int fragment_count;

  // Idle percentages for the sender and the receiver; zero turns idling off.
  int idle_rate;
  int stall_rate;
  // Each increment asks the receiver for one long hold-off.
  int hold_requests;
  int settings_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ipv4_fragment_header_gen u_dut (.*);

  ipv4_fragment_header_gen_checker u_checker (.*);

  // Hand one datagram length to the block. An optional idle burst comes
  // first, so valid is never dropped and raised again within one time step.
  task automatic send_datagram(input logic [15:0] len);
    if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_payload_length <= len;
    do @(posedge clk); while (in_stall);
  endtask

  // Register write on the configuration channel. The trailing wait keeps two
  // back-to-back writes from touching cfg_valid twice in one step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering items and wait until every predicted fragment has come out,
  // then give the block time to fall idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] units, input logic [31:0] src,
                                input logic [31:0] dst, input logic [7:0] ttl,
                                input logic [7:0] tos, input logic [7:0] proto);
    write_reg(REG_MAX_UNITS, {24'h0, units});
    write_reg(REG_SRC_ADDR, src);
    write_reg(REG_DST_ADDR, dst);
    write_reg(REG_TTL, {24'h0, ttl});
    write_reg(REG_TOS, {24'h0, tos});
    write_reg(REG_PROTO, {24'h0, proto});
    settings_count++;
  endtask

  // Random datagram length. Half are short to keep the run quick; the rest
  // are full range, zero, or sit next to a multiple of the largest and the
  // smallest fragment size so that the last fragment is tiny or exactly full.
  function automatic logic [15:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'd0;
    if (sel <= 2) return 16'($urandom);
    if (sel == 3) return 16'($urandom_range(1, 45) * 1440 + $urandom_range(0, 2));
    if (sel == 4) return 16'($urandom_range(1, 63) * 1024 + $urandom_range(0, 2) - 1);
    return 16'($urandom_range(1, 3000));
  endfunction

  // Result side: short random stall bursts, plus one long hold-off when the
  // stimulus asks for it. The hold-off is timed here, in cycles.
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    out_stall  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_rate > 0 && $urandom_range(0, 99) < stall_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] lens[$];
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_payload_length = '0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_MAX_UNITS;
    cfg_data          = '0;
    idle_rate         = 20;
    stall_rate        = 20;
    hold_requests     = 0;
    settings_count    = 1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values (1440-byte fragments). Zero length, lengths
    // around one and two full fragments, and the largest length.
    lens = '{16'd0, 16'd1, 16'd7, 16'd8, 16'd9, 16'd1439, 16'd1440, 16'd1441,
             16'd2880, 16'hFFFF};
    foreach (lens[i]) send_datagram(lens[i]);
    drain_results();

    // Smallest fragment size and all-zero header fields. The largest length
    // now needs all 64 fragments. Alternating bit patterns toggle every bit
    // of the length field.
    apply_settings(UNITS_MIN, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
    lens = '{16'd1023, 16'd1024, 16'd1025, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000};
    foreach (lens[i]) send_datagram(lens[i]);
    drain_results();

    // A fragment size of zero units must act as the smallest size. All other
    // fields are all ones, and writes to the unused indexes must change
    // nothing.
    apply_settings(8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    write_reg(REG_SPARE_A, 32'h0000_0055);
    write_reg(REG_SPARE_B, 32'h0000_0001);
    lens = '{16'd1025, 16'hFFFF, 16'd2};
    foreach (lens[i]) send_datagram(lens[i]);
    drain_results();

    // An oversized fragment size must act as the largest. Midway the
    // receiver holds off for a long stretch while medium datagrams keep
    // coming, so the result path backs up into the input.
    apply_settings(8'hFF, $urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 30; i++) begin
      if (i == 10) hold_requests++;
      if (i >= 10 && i < 18) send_datagram(16'($urandom_range(3000, 6000)));
      else send_datagram(pick_length());
    end
    drain_results();

    // Any legal fragment size with random header fields, busier idling.
    idle_rate  = 35;
    stall_rate = 35;
    apply_settings(8'($urandom_range(UNITS_MIN, UNITS_MAX)), $urandom, $urandom,
                   8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 25; i++) send_datagram(pick_length());
    drain_results();

    // Just outside the legal range on either side; the final stretch runs
    // with neither side idling.
    idle_rate  = 15;
    stall_rate = 15;
    apply_settings($urandom_range(0, 1) ? 8'd127 : 8'd181, $urandom, $urandom,
                   8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 25; i++) begin
      if (i == 15) begin
        idle_rate  = 0;
        stall_rate = 0;
      end
      send_datagram(pick_length());
    end
    drain_results();

    $display("Covered %0d datagrams yielding %0d fragments under %0d register settings,",
             datagram_count, fragment_count, settings_count);
    $display("with clamped fragment sizes, zero lengths and a long output hold-off.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
